@@ hw/rtl/terrain_height_query_top_macros.svh @@
// assertion macros for the terrain height query block
// used by terrain_height_query_top; expects clk and rst_n in scope
`ifndef TERRAIN_HEIGHT_QUERY_TOP_MACROS_SVH
`define TERRAIN_HEIGHT_QUERY_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define THQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define THQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/thq_pkg.sv @@
// shared constants, types and helper functions for the terrain height query block
// no dependencies
package thq_pkg;

  localparam int GRID_CELLS        = 63;
  localparam int VERTICES_PER_SIDE = 64;
  localparam int STORE_DEPTH       = 4096;
  localparam int ADDR_W            = $clog2(STORE_DEPTH);
  localparam int H_W               = 16;
  localparam int FRAC_ONE          = 256;
  localparam int FRAC_W            = 9;
  localparam int CELL_W            = 8;
  localparam int ROW_W             = CELL_W + 1;
  localparam int ACC_W             = 27;
  localparam int LIMIT_W           = 17;
  localparam logic [LIMIT_W-1:0] COORD_LIMIT = LIMIT_W'(GRID_CELLS * FRAC_ONE);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [FRAC_W-1:0] frac_t;

  // load strobes from the sequencer into the multiply-accumulate unit
  typedef struct packed {
    logic ld_hc;
    logic ld_p1;
    logic ld_p2;
  } mac_ctl_t;

  // row-major address, wrapped to the store depth
  function automatic addr_t vertex_addr(input logic [ROW_W-1:0] row,
                                        input logic [ROW_W-1:0] col);
    logic [2*ROW_W+1:0] full;
    full = (2*ROW_W+2)'(row) * (2*ROW_W+2)'(VERTICES_PER_SIDE) + (2*ROW_W+2)'(col);
    return full[ADDR_W-1:0];
  endfunction

  // round half up to the integer part and saturate to q8.8
  function automatic logic signed [H_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] biased;
    logic signed [ACC_W-9:0] q;
    biased = acc + ACC_W'(128);
    q      = biased[ACC_W-1:8];
    if (q > (ACC_W-8)'(32767)) begin
      return 16'sh7fff;
    end else if (q < -(ACC_W-8)'(32768)) begin
      return 16'sh8000;
    end
    return q[H_W-1:0];
  endfunction

endpackage

@@ hw/rtl/terrain_height_query_top.sv @@
// top level of the terrain height query block: sequencer, address logic, output register
// depends on thq_pkg, thq_ram, thq_mac and terrain_height_query_top_macros.svh
//
// usage
//   the block holds a square grid of q8.8 vertex heights in a 4096 x 16 store
//   an item is taken at a rising edge with start high and busy low
//   in_mode 0 writes in_new_height at in_vertex_index; in_mode 1 queries the
//   interpolated height at (in_query_x, in_query_z), both q8.8 grid units
//   each item gives exactly one result, shown for one cycle with out_valid high:
//     write: out_height_out echoes the height, out_in_range is 1
//     query outside the grid: out_height_out 0, out_in_range 0
//     query inside: rounded, saturated triangle interpolation, out_in_range 1
// throughput and item sequence
//   write: result in the cycle after the accept edge; busy stays low, so a
//   write can be taken every cycle
//   query: busy is high from split through the reads to sum, which sets the result;
//   a query needs three corner heights from the single read port of the
//   store, one per cycle, and the shared multiplier takes two weights in turn
//   query out of range: the split state gives the result; only it has busy high
// reset
//   synchronous active-low reset returns the sequencer to idle and clears the
//   strobe; the height store itself is not cleared and must be written first
// the receiver cannot stall: results are never held back
`include "terrain_height_query_top_macros.svh"

module terrain_height_query_top import thq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_mode,
  input  logic [11:0]           in_vertex_index,
  input  logic signed [15:0]    in_new_height,
  input  logic signed [15:0]    in_query_x,
  input  logic signed [15:0]    in_query_z,
  output logic                  out_valid,
  output logic signed [15:0]    out_height_out,
  output logic                  out_in_range
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_RD_C,
    ST_RD_1,
    ST_RD_2,
    ST_P2,
    ST_SUM
  } state_t;

  state_t                state_r;
  logic                  out_valid_r;
  logic signed [H_W-1:0] out_height_r;
  logic                  out_in_range_r;

  // query coordinates and derived addresses, weights
  logic signed [H_W-1:0] qx_r, qz_r;
  addr_t                 addr_c_r, addr_1_r, addr_2_r;
  frac_t                 w1_r, w2_r;

  logic                  accept;
  logic                  out_of_range;
  logic [CELL_W-1:0]     ix, iz;
  frac_t                 fx, fz;
  logic [FRAC_W:0]       frac_sum;
  logic                  lower_tri;
  logic [ROW_W-1:0]      row0, row1, col0, col1;
  addr_t                 rd_addr;
  logic [H_W-1:0]        rd_data;
  mac_ctl_t              mac_ctl;
  logic signed [H_W-1:0] mac_result;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // range check: negative, or beyond the far edge
  assign out_of_range = qx_r[H_W-1] || qz_r[H_W-1]
                     || (LIMIT_W'(qx_r[H_W-2:0]) > COORD_LIMIT)
                     || (LIMIT_W'(qz_r[H_W-2:0]) > COORD_LIMIT);

  // split into cell and fraction; the far edge falls into the last cell
  always_comb begin
    ix = CELL_W'(qx_r[H_W-2:8]);
    fx = FRAC_W'(qx_r[7:0]);
    if (ix >= CELL_W'(GRID_CELLS)) begin
      ix = CELL_W'(GRID_CELLS - 1);
      fx = FRAC_W'(FRAC_ONE);
    end
    iz = CELL_W'(qz_r[H_W-2:8]);
    fz = FRAC_W'(qz_r[7:0]);
    if (iz >= CELL_W'(GRID_CELLS)) begin
      iz = CELL_W'(GRID_CELLS - 1);
      fz = FRAC_W'(FRAC_ONE);
    end
  end

  assign frac_sum  = (FRAC_W+1)'(fx) + (FRAC_W+1)'(fz);
  assign lower_tri = (frac_sum < (FRAC_W+1)'(FRAC_ONE));
  assign row0      = ROW_W'(iz);
  assign row1      = ROW_W'(iz) + ROW_W'(1);
  assign col0      = ROW_W'(ix);
  assign col1      = ROW_W'(ix) + ROW_W'(1);

  // read address follows the corner being fetched: corner, then h1, then h2
  always_comb begin
    unique case (state_r)
      ST_RD_1: rd_addr = addr_1_r;
      ST_RD_2: rd_addr = addr_2_r;
      default: rd_addr = addr_c_r;
    endcase
  end

  // mac strobes line up with the registered read data
  always_comb begin
    mac_ctl       = '0;
    mac_ctl.ld_hc = (state_r == ST_RD_1);
    mac_ctl.ld_p1 = (state_r == ST_RD_2);
    mac_ctl.ld_p2 = (state_r == ST_P2);
  end

  thq_ram #(
    .DEPTH  (STORE_DEPTH),
    .WIDTH  (H_W),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && !in_mode),
    .wr_addr (in_vertex_index),
    .wr_data (in_new_height),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  thq_mac u_mac (
    .clk       (clk),
    .ctl       (mac_ctl),
    .rd_height ($signed(rd_data)),
    .w1        (w1_r),
    .w2        (w2_r),
    .result    (mac_result)
  );

  // sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (!in_mode) begin
              // write completes at once, echo the stored height
              out_valid_r    <= 1'b1;
              out_height_r   <= in_new_height;
              out_in_range_r <= 1'b1;
            end else begin
              qx_r    <= in_query_x;
              qz_r    <= in_query_z;
              state_r <= ST_SPLIT;
            end
          end
        end
        ST_SPLIT: begin
          if (out_of_range) begin
            out_valid_r    <= 1'b1;
            out_height_r   <= '0;
            out_in_range_r <= 1'b0;
            state_r        <= ST_IDLE;
          end else begin
            addr_1_r <= vertex_addr(row1, col0);
            addr_2_r <= vertex_addr(row0, col1);
            if (lower_tri) begin
              addr_c_r <= vertex_addr(row0, col0);
              w1_r     <= fz;
              w2_r     <= fx;
            end else begin
              addr_c_r <= vertex_addr(row1, col1);
              w1_r     <= FRAC_W'(FRAC_ONE) - fx;
              w2_r     <= FRAC_W'(FRAC_ONE) - fz;
            end
            state_r <= ST_RD_C;
          end
        end
        ST_RD_C: state_r <= ST_RD_1;
        ST_RD_1: state_r <= ST_RD_2;
        ST_RD_2: state_r <= ST_P2;
        ST_P2:   state_r <= ST_SUM;
        ST_SUM: begin
          out_valid_r    <= 1'b1;
          out_height_r   <= mac_result;
          out_in_range_r <= 1'b1;
          state_r        <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_height_out = out_height_r;
  assign out_in_range   = out_in_range_r;

  // a write gives its result in the very next cycle
  `THQ_ASSERT_NXT(a_write_result, accept && !in_mode, out_valid && out_in_range, "write without result")
  // a query occupies the block right after it is taken
  `THQ_ASSERT_NXT(a_query_busy, accept && in_mode, busy && !out_valid, "query not started")
  // results only leave once the sequencer is back in idle
  `THQ_ASSERT_IMP(a_result_idle, out_valid, !busy, "result while busy")
  // an out-of-range result carries a zero height
  `THQ_ASSERT_IMP(a_oor_zero, out_valid && !out_in_range, out_height_out == 16'sd0, "nonzero height out of range")

endmodule

@@ hw/rtl/thq_ram.sv @@
// single-port-write, single-port-read synchronous ram with registered read data
// generic; no package dependency
module thq_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/thq_mac.sv @@
// shared multiplier and accumulator for the triangle interpolation
// depends on thq_pkg
module thq_mac import thq_pkg::*; (
  input  logic                    clk,
  input  mac_ctl_t                ctl,
  input  logic signed [H_W-1:0]   rd_height,
  input  frac_t                   w1,
  input  frac_t                   w2,
  output logic signed [H_W-1:0]   result
);

  logic signed [H_W-1:0]   hc_r;
  logic signed [ACC_W-1:0] prod1_r;
  logic signed [ACC_W-1:0] prod2_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [H_W:0]     diff;
  logic signed [FRAC_W:0]  weight;
  logic signed [ACC_W-1:0] prod;

  // one multiplier, weight picked by which corner is on the read port
  assign diff   = (H_W+1)'(rd_height) - (H_W+1)'(hc_r);
  assign weight = ctl.ld_p2 ? $signed({1'b0, w2}) : $signed({1'b0, w1});
  assign prod   = ACC_W'(diff) * ACC_W'(weight);

  always_ff @(posedge clk) begin
    if (ctl.ld_hc) begin
      hc_r <= rd_height;
    end
    if (ctl.ld_p1) begin
      prod1_r <= prod;
    end
    if (ctl.ld_p2) begin
      prod2_r <= prod;
      acc_r   <= (ACC_W'(hc_r) <<< 8) + prod1_r;
    end
  end

  assign result = round_sat(acc_r + prod2_r);

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for terrain_height_query_top: writes vertex heights, queries points
// and checks every result against a shadow height grid; depends on thq_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_top;
  import thq_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int COORD_MAX   = GRID_CELLS * FRAC_ONE;  // far edge in q8.8
  localparam int DRAIN_LIMIT = 200;

  // item kinds carried on in_mode
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // one result as the block should present it
  typedef struct {
    logic signed [15:0] height;
    logic               in_range;
  } height_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_mode = MODE_WRITE;
  logic [11:0] in_vertex_index = '0;
  logic signed [15:0] in_new_height = '0;
  logic signed [15:0] in_query_x = '0;
  logic signed [15:0] in_query_z = '0;
  logic busy;
  logic out_valid;
  logic signed [15:0] out_height_out;
  logic out_in_range;

  // shadow of the height store plus a map of which vertices hold real data
  logic signed [15:0] vertex_heights [STORE_DEPTH];
  bit                 vertex_loaded  [STORE_DEPTH];

  // results owed by the block, oldest first
  height_result_t pending_heights[$];

  int fail_count = 0;
  int gap_pct = 0;  // chance in percent of an idle burst before an item
  int n_writes = 0;
  int n_inside = 0;
  int n_outside = 0;
  int n_upper = 0;
  int n_far_edge = 0;

  terrain_height_query_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_vertex_index(in_vertex_index),
    .in_new_height  (in_new_height),
    .in_query_x     (in_query_x),
    .in_query_z     (in_query_z),
    .out_valid      (out_valid),
    .out_height_out (out_height_out),
    .out_in_range   (out_in_range)
  );

  // 20 ns clock
  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // height grid predictor
  // ---------------------------------------------------------------------------

  // row-major store address, wrapped to the store depth
  function automatic int vertex_at(input int row, input int col);
    return (row * VERTICES_PER_SIDE + col) % STORE_DEPTH;
  endfunction

  function automatic bit coord_inside(input logic signed [15:0] x, input logic signed [15:0] z);
    return int'(x) >= 0 && int'(z) >= 0 && int'(x) <= COORD_MAX && int'(z) <= COORD_MAX;
  endfunction

  // cell index and q0.8 fraction; the far edge folds into the last cell with fraction one
  function automatic void fold_coord(input int c, output int cell_idx, output int frac);
    cell_idx = c >> 8;
    frac = c & 255;
    if (cell_idx >= GRID_CELLS) begin
      cell_idx = GRID_CELLS - 1;
      frac = FRAC_ONE;
    end
  endfunction

  // the corners h1, h2 and hc that a query reads, and the weights w1, w2 of the edge vertices
  // lower triangle pivots on (iz, ix), upper on (iz+1, ix+1)
  function automatic void pick_triangle(input int x, input int z, output int addr_h1,
                                        output int addr_h2, output int addr_hc,
                                        output int w1, output int w2, output bit upper);
    int ix, iz, fx, fz;
    fold_coord(x, ix, fx);
    fold_coord(z, iz, fz);
    addr_h1 = vertex_at(iz + 1, ix);
    addr_h2 = vertex_at(iz, ix + 1);
    upper = (fx + fz >= FRAC_ONE);
    if (upper) begin
      addr_hc = vertex_at(iz + 1, ix + 1);
      w1 = FRAC_ONE - fx;
      w2 = FRAC_ONE - fz;
    end else begin
      addr_hc = vertex_at(iz, ix);
      w1 = fz;
      w2 = fx;
    end
  endfunction

  // applies one accepted item to the shadow grid and returns the result it owes
  function automatic height_result_t predict_result(input logic mode,
                                                    input logic [11:0] idx,
                                                    input logic signed [15:0] new_h,
                                                    input logic signed [15:0] qx,
                                                    input logic signed [15:0] qz);
    height_result_t r;
    int a1, a2, ac, w1, w2;
    bit upper;
    longint h1, h2, hc, acc, q;
    if (mode == MODE_WRITE) begin
      vertex_heights[idx] = new_h;
      vertex_loaded[idx] = 1'b1;
      r.height = new_h;
      r.in_range = 1'b1;
      n_writes++;
    end else if (!coord_inside(qx, qz)) begin
      r.height = '0;
      r.in_range = 1'b0;
      n_outside++;
    end else begin
      pick_triangle(int'(qx), int'(qz), a1, a2, ac, w1, w2, upper);
      h1 = vertex_heights[a1];
      h2 = vertex_heights[a2];
      hc = vertex_heights[ac];
      acc = hc * FRAC_ONE + (h1 - hc) * w1 + (h2 - hc) * w2;
      q = (acc + 128) >>> 8;  // round half up, floor for negatives
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r.height = 16'(q);
      r.in_range = 1'b1;
      n_inside++;
      if (upper) n_upper++;
      if (int'(qx) == COORD_MAX || int'(qz) == COORD_MAX) n_far_edge++;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // item driver
  // ---------------------------------------------------------------------------

  // drives one item and holds it until the block takes it; start stays high
  // into the next item unless an idle burst comes first
  task automatic send_item(input logic mode, input logic [11:0] idx,
                           input logic signed [15:0] new_h,
                           input logic signed [15:0] qx, input logic signed [15:0] qz);
    height_result_t owed;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_vertex_index <= idx;
    in_new_height <= new_h;
    in_query_x <= qx;
    in_query_z <= qz;
    // busy read here is its value just before the edge
    do @(posedge clk); while (busy !== 1'b0);
    owed = predict_result(mode, idx, new_h, qx, qz);
    pending_heights.insert(pending_heights.size(), owed);
  endtask

  task automatic send_write(input int idx, input logic signed [15:0] h);
    send_item(MODE_WRITE, 12'(idx), h, 16'($urandom()), 16'($urandom()));
  endtask

  // heights lean toward the extremes and small values around zero
  function automatic logic signed [15:0] pick_height();
    case ($urandom_range(0, 5))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom());
    endcase
  endfunction

  // a query inside the grid first loads any corner it would read that has
  // never been written, since those entries hold nothing defined
  task automatic send_query(input int x, input int z);
    int a[3];
    int w1, w2;
    bit upper;
    logic signed [15:0] x16, z16;
    x16 = 16'(x);
    z16 = 16'(z);
    if (coord_inside(x16, z16)) begin
      pick_triangle(int'(x16), int'(z16), a[0], a[1], a[2], w1, w2, upper);
      foreach (a[k]) begin
        if (!vertex_loaded[a[k]]) send_write(a[k], pick_height());
      end
    end
    send_item(MODE_QUERY, 12'($urandom()), 16'($urandom()), x16, z16);
  endtask

  // coordinate inside the grid, with weight on grid lines and the far edge
  function automatic int pick_inside_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_MAX;
      1:       return FRAC_ONE * $urandom_range(0, GRID_CELLS);
      2:       return FRAC_ONE * $urandom_range(0, GRID_CELLS - 1) + 255;
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  // coordinate that is mostly outside: just past either edge or anything at all
  function automatic int pick_outside_coord();
    case ($urandom_range(0, 3))
      0:       return COORD_MAX + $urandom_range(1, 300);
      1:       return -int'($urandom_range(1, 300));
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: the block cannot be stalled, so every strobe is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    height_result_t oldest;
    if (rst_n && out_valid) begin
      if (pending_heights.size() == 0) begin
        $error("result with no item pending: height_out %0d in_range %0b",
               out_height_out, out_in_range);
        fail_count++;
      end else begin
        oldest = pending_heights.pop_front();
        if (out_height_out !== oldest.height) begin
          $error("height_out: expected %0d, got %0d", oldest.height, out_height_out);
          fail_count++;
        end
        if (out_in_range !== oldest.in_range) begin
          $error("in_range: expected %0b, got %0b", oldest.in_range, out_in_range);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked points: both triangles and their shared diagonal, the far edge,
  // full-scale heights and every way a query can fall outside
  task automatic test_directed_corners();
    gap_pct = 0;
    // first cell with extreme and unit heights
    send_write(vertex_at(0, 0), 16'sh7fff);
    send_write(vertex_at(0, 1), 16'sh8000);
    send_write(vertex_at(1, 0), 16'sh0100);
    send_write(vertex_at(1, 1), -16'sh0100);
    send_query(0, 0);        // pivot vertex alone
    send_query(255, 0);      // along x, lower triangle
    send_query(127, 128);    // fractions sum just under one
    send_query(128, 128);    // fractions sum to one, upper triangle
    send_query(255, 255);    // deep in the upper triangle
    // last cell held at full scale, reached directly and through the far edge fold
    send_write(vertex_at(GRID_CELLS - 1, GRID_CELLS - 1), 16'sh7fff);
    send_write(vertex_at(GRID_CELLS - 1, GRID_CELLS), 16'sh7fff);
    send_write(vertex_at(GRID_CELLS, GRID_CELLS - 1), 16'sh7fff);
    send_write(vertex_at(GRID_CELLS, GRID_CELLS), 16'sh7fff);
    send_query(COORD_MAX, COORD_MAX);
    send_query(COORD_MAX, COORD_MAX - 128);
    send_query(COORD_MAX - 128, COORD_MAX);
    send_query(COORD_MAX - 1, COORD_MAX - 1);
    // outside on each side and at the ends of the coordinate range
    send_query(-1, 0);
    send_query(0, -1);
    send_query(COORD_MAX + 1, 0);
    send_query(0, COORD_MAX + 1);
    send_query(-32768, -32768);
    send_query(32767, 32767);
  endtask

  // writes spread over the whole index range, with idle bursts between
  task automatic test_scattered_writes(input int count);
    gap_pct = 30;
    repeat (count) send_write($urandom_range(0, STORE_DEPTH - 1), pick_height());
  endtask

  // load a small patch of the grid, then sample many points across it;
  // every fifth patch sits in the far corner so the edge fold gets traffic
  task automatic test_patch_sweeps(input int patch_count);
    int span, row0, col0, x_hi, z_hi;
    for (int p = 0; p < patch_count; p++) begin
      span = $urandom_range(2, 5);
      if (p % 5 == 0) begin
        row0 = VERTICES_PER_SIDE - span;
        col0 = VERTICES_PER_SIDE - span;
      end else begin
        row0 = $urandom_range(0, VERTICES_PER_SIDE - span);
        col0 = $urandom_range(0, VERTICES_PER_SIDE - span);
      end
      // every third patch runs without idle bursts, the others with them
      gap_pct = (p % 3 == 0) ? 0 : 25;
      for (int r = 0; r < span; r++) begin
        for (int c = 0; c < span; c++) begin
          send_write(vertex_at(row0 + r, col0 + c), pick_height());
        end
      end
      x_hi = (col0 + span - 1) * FRAC_ONE;
      z_hi = (row0 + span - 1) * FRAC_ONE;
      repeat ($urandom_range(15, 40)) begin
        send_query($urandom_range(col0 * FRAC_ONE, x_hi), $urandom_range(row0 * FRAC_ONE, z_hi));
      end
    end
  endtask

  // queries anywhere, a share of them outside, mixed with stray writes
  task automatic test_random_queries(input int count);
    gap_pct = 20;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0:       send_query(pick_outside_coord(), pick_inside_coord());
        1:       send_query(pick_inside_coord(), pick_outside_coord());
        2:       send_query(pick_outside_coord(), pick_outside_coord());
        3:       send_write($urandom_range(0, STORE_DEPTH - 1), pick_height());
        default: send_query(pick_inside_coord(), pick_inside_coord());
      endcase
    end
  endtask

  // closing stretch with start held high: writes right behind queries and back
  task automatic test_back_to_back(input int count);
    gap_pct = 0;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_write($urandom_range(0, STORE_DEPTH - 1), pick_height());
        3:       send_query(pick_outside_coord(), pick_inside_coord());
        default: send_query(pick_inside_coord(), pick_inside_coord());
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------
  initial begin
    int drain_cycles;
    foreach (vertex_loaded[k]) vertex_loaded[k] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_scattered_writes(150);
    test_patch_sweeps(15);
    test_random_queries(200);
    test_back_to_back(150);

    start <= 1'b0;
    drain_cycles = 0;
    while (pending_heights.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    // leave room for any stray strobe after the last result
    repeat (10) @(posedge clk);
    if (pending_heights.size() != 0) begin
      $error("%0d results never arrived", pending_heights.size());
      fail_count++;
    end

    $display("covered %0d writes and %0d queries: %0d inside, %0d outside",
             n_writes, n_inside + n_outside, n_inside, n_outside);
    $display("inside queries: %0d on the upper triangle, %0d on the far edge",
             n_upper, n_far_edge);
    if (fail_count == 0) begin
      $display("[terrain_height_query_top] OK");
    end else begin
      $display("[terrain_height_query_top] ERROR");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #(longint'(CYCLE_LIMIT) * CLK_PERIOD);
    $error("run timed out after %0d cycles", CYCLE_LIMIT);
    $display("[terrain_height_query_top] ERROR");
    $finish;
  end

endmodule
